// ===== hdl/ggh_pkg.sv =====
`default_nettype none

package ggh_pkg;

    // grid geometry
    localparam int GRID_X     = 16;
    localparam int GRID_Y     = 16;
    localparam int GRID_Z     = 16;
    localparam int COORD_W    = 4;
    localparam int GRID_CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int GRID_AW    = $clog2(GRID_CELLS);

    // halo faces, all sized to the largest face
    localparam int FACE_YZ    = GRID_Y * GRID_Z;
    localparam int FACE_XZ    = GRID_X * GRID_Z;
    localparam int FACE_XY    = GRID_X * GRID_Y;
    localparam int FACE_MAX1  = (FACE_XZ > FACE_XY) ? FACE_XZ : FACE_XY;
    localparam int HALO_FACE  = (FACE_YZ > FACE_MAX1) ? FACE_YZ : FACE_MAX1;
    localparam int FACE_COUNT = 6;
    localparam int HALO_DEPTH = FACE_COUNT * HALO_FACE;
    localparam int HALO_AW    = $clog2(HALO_DEPTH);

    // data path
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CFG_IDX_W  = 1;

    // command codes
    localparam logic [1:0] CMD_GRID  = 2'd0;
    localparam logic [1:0] CMD_HALO  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // face codes, also the neighbour mask bit numbers
    localparam logic [2:0] FACE_XL = 3'd0;
    localparam logic [2:0] FACE_XH = 3'd1;
    localparam logic [2:0] FACE_YL = 3'd2;
    localparam logic [2:0] FACE_YH = 3'd3;
    localparam logic [2:0] FACE_ZL = 3'd4;
    localparam logic [2:0] FACE_ZH = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RES = 1'd1;

    localparam logic [DATA_W-1:0] INV_RES_RESET = 32'd65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [2:0]                face;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic [COORD_W-1:0]        pos_z;
        logic signed [DATA_W-1:0]  sample;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  grad_x;
        logic signed [DATA_W-1:0]  grad_y;
        logic signed [DATA_W-1:0]  grad_z;
        logic                      clipped;
    } result_t;

    function automatic logic [GRID_AW-1:0] grid_addr(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        int a;
        a = (int'(x) * GRID_Y + int'(y)) * GRID_Z + int'(z);
        return GRID_AW'(a);
    endfunction

    function automatic logic [HALO_AW-1:0] halo_addr(
        input logic [2:0]         face,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        int loc;
        case (face)
            FACE_XL, FACE_XH: loc = GRID_Z * int'(y) + int'(z);
            FACE_YL, FACE_YH: loc = GRID_Z * int'(x) + int'(z);
            default:          loc = GRID_Y * int'(x) + int'(y);
        endcase
        return HALO_AW'(int'(face) * HALO_FACE + loc);
    endfunction

    function automatic logic in_grid(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        return (int'(x) < GRID_X) && (int'(y) < GRID_Y) && (int'(z) < GRID_Z);
    endfunction

    // halo load legality: known face and used coordinates in the grid
    function automatic logic halo_ok(
        input logic [2:0]         face,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        logic ok;
        case (face)
            FACE_XL, FACE_XH: ok = (int'(y) < GRID_Y) && (int'(z) < GRID_Z);
            FACE_YL, FACE_YH: ok = (int'(x) < GRID_X) && (int'(z) < GRID_Z);
            FACE_ZL, FACE_ZH: ok = (int'(x) < GRID_X) && (int'(y) < GRID_Y);
            default:          ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/grid_gradient_3d_halo.sv =====
`default_nettype none

// loads (grid or halo sample) are written at the accepting edge and can follow back to back while not busy
// a query runs from the accepting edge through ISSUE and DRAIN to its result strobe; busy
// stays high until the strobe, so no item is taken meanwhile; reads issue one axis per cycle
// on the two read ports of each store, with the multiply and saturate stages behind them
// the result is shown for exactly one cycle on result_valid; the receiver cannot stall
// reset clears the sequencer, pipeline valids and config (mask 0, scale 1.0); stores keep junk
module grid_gradient_3d_halo (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // command side
    input  wire                                   start,
    output logic                                  busy,
    input  ggh_pkg::item_t                        item,
    // result side
    output logic                                  result_valid,
    output ggh_pkg::result_t                      result,
    // configuration
    input  wire                                   cfg_write,
    input  wire [ggh_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire [ggh_pkg::DATA_W-1:0]             cfg_data
);

    // config registers
    logic [5:0]                    mask_reg;
    logic [ggh_pkg::DATA_W-1:0]    inv_res_reg;

    // sequencer
    ggh_pkg::state_t               state_reg, state_next;
    ggh_pkg::axis_t                issue_axis_reg, issue_axis_next;
    logic                          issue;

    // captured query point
    logic [ggh_pkg::COORD_W-1:0]   qx_reg, qy_reg, qz_reg;

    // stores: one write port, two read ports each, registered read data
    logic [ggh_pkg::DATA_W-1:0]    grid_mem [ggh_pkg::GRID_CELLS];
    logic [ggh_pkg::DATA_W-1:0]    halo_mem [ggh_pkg::HALO_DEPTH];

    logic                          accept;
    logic                          query_ok;
    logic                          grid_we;
    logic                          halo_we;

    // read issue addresses for the current axis
    logic [ggh_pkg::GRID_AW-1:0]   ga_prev, ga_next;
    logic [ggh_pkg::HALO_AW-1:0]   ha_prev, ha_next;
    logic                          sel_prev_halo, sel_next_halo;
    logic [2:0]                    face_lo, face_hi;
    logic                          at_lo, at_hi, mask_lo, mask_hi;

    // read stage
    logic [ggh_pkg::DATA_W-1:0]    grid_prev_reg, grid_next_reg;
    logic [ggh_pkg::DATA_W-1:0]    halo_prev_reg, halo_next_reg;
    logic                          rd_sel_prev_reg, rd_sel_next_reg;
    logic                          rd_vld_reg;
    ggh_pkg::axis_t                rd_axis_reg;

    // multiply stage
    logic [ggh_pkg::DATA_W-1:0]    prev_val, next_val;
    logic signed [ggh_pkg::DIFF_W-1:0] diff;
    logic signed [ggh_pkg::PROD_W-1:0] prod;
    logic signed [ggh_pkg::PROD_W-1:0] prod_reg;
    logic                          mul_vld_reg;
    ggh_pkg::axis_t                mul_axis_reg;

    // saturate stage
    logic [ggh_pkg::PROD_W-1:ggh_pkg::FRAC_W+ggh_pkg::DATA_W-1] top_bits;
    logic                          sat;
    logic signed [ggh_pkg::DATA_W-1:0] comp;
    logic                          clip_reg;
    ggh_pkg::result_t              result_reg;
    logic                          result_valid_reg;

    assign busy     = (state_reg != ggh_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign query_ok = accept && (item.cmd == ggh_pkg::CMD_QUERY)
                      && ggh_pkg::in_grid(item.pos_x, item.pos_y, item.pos_z);
    assign grid_we  = accept && (item.cmd == ggh_pkg::CMD_GRID)
                      && ggh_pkg::in_grid(item.pos_x, item.pos_y, item.pos_z);
    assign halo_we  = accept && (item.cmd == ggh_pkg::CMD_HALO)
                      && ggh_pkg::halo_ok(item.face, item.pos_x, item.pos_y, item.pos_z);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            inv_res_reg <= ggh_pkg::INV_RES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ggh_pkg::CFG_MASK:    mask_reg    <= cfg_data[5:0];
                ggh_pkg::CFG_INV_RES: inv_res_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // sequencer: issue one axis per cycle, then wait for the last axis to leave the multiplier
    always_comb
    begin
        state_next      = state_reg;
        issue_axis_next = issue_axis_reg;
        issue           = 1'b0;
        case (state_reg)
            ggh_pkg::ST_IDLE:
            begin
                if (query_ok)
                begin
                    state_next      = ggh_pkg::ST_ISSUE;
                    issue_axis_next = ggh_pkg::AXIS_X;
                end
            end
            ggh_pkg::ST_ISSUE:
            begin
                issue = 1'b1;
                case (issue_axis_reg)
                    ggh_pkg::AXIS_X: issue_axis_next = ggh_pkg::AXIS_Y;
                    ggh_pkg::AXIS_Y: issue_axis_next = ggh_pkg::AXIS_Z;
                    default:
                    begin
                        issue_axis_next = ggh_pkg::AXIS_X;
                        state_next      = ggh_pkg::ST_DRAIN;
                    end
                endcase
            end
            ggh_pkg::ST_DRAIN:
            begin
                if (mul_vld_reg && (mul_axis_reg == ggh_pkg::AXIS_Z))
                    state_next = ggh_pkg::ST_IDLE;
            end
            default:
                state_next = ggh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ggh_pkg::ST_IDLE;
            issue_axis_reg <= ggh_pkg::AXIS_X;
        end
        else
        begin
            state_reg      <= state_next;
            issue_axis_reg <= issue_axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_ok)
        begin
            qx_reg <= item.pos_x;
            qy_reg <= item.pos_y;
            qz_reg <= item.pos_z;
        end
    end

    // neighbour addresses; at an edge the grid port reads the point itself
    always_comb
    begin
        case (issue_axis_reg)
            ggh_pkg::AXIS_X:
            begin
                at_lo   = (int'(qx_reg) == 0);
                at_hi   = (int'(qx_reg) == ggh_pkg::GRID_X - 1);
                mask_lo = mask_reg[ggh_pkg::FACE_XL];
                mask_hi = mask_reg[ggh_pkg::FACE_XH];
                face_lo = ggh_pkg::FACE_XL;
                face_hi = ggh_pkg::FACE_XH;
                ga_prev = ggh_pkg::grid_addr(qx_reg - 1'b1, qy_reg, qz_reg);
                ga_next = ggh_pkg::grid_addr(qx_reg + 1'b1, qy_reg, qz_reg);
            end
            ggh_pkg::AXIS_Y:
            begin
                at_lo   = (int'(qy_reg) == 0);
                at_hi   = (int'(qy_reg) == ggh_pkg::GRID_Y - 1);
                mask_lo = mask_reg[ggh_pkg::FACE_YL];
                mask_hi = mask_reg[ggh_pkg::FACE_YH];
                face_lo = ggh_pkg::FACE_YL;
                face_hi = ggh_pkg::FACE_YH;
                ga_prev = ggh_pkg::grid_addr(qx_reg, qy_reg - 1'b1, qz_reg);
                ga_next = ggh_pkg::grid_addr(qx_reg, qy_reg + 1'b1, qz_reg);
            end
            default:
            begin
                at_lo   = (int'(qz_reg) == 0);
                at_hi   = (int'(qz_reg) == ggh_pkg::GRID_Z - 1);
                mask_lo = mask_reg[ggh_pkg::FACE_ZL];
                mask_hi = mask_reg[ggh_pkg::FACE_ZH];
                face_lo = ggh_pkg::FACE_ZL;
                face_hi = ggh_pkg::FACE_ZH;
                ga_prev = ggh_pkg::grid_addr(qx_reg, qy_reg, qz_reg - 1'b1);
                ga_next = ggh_pkg::grid_addr(qx_reg, qy_reg, qz_reg + 1'b1);
            end
        endcase
        if (at_lo)
            ga_prev = ggh_pkg::grid_addr(qx_reg, qy_reg, qz_reg);
        if (at_hi)
            ga_next = ggh_pkg::grid_addr(qx_reg, qy_reg, qz_reg);
        ha_prev       = ggh_pkg::halo_addr(face_lo, qx_reg, qy_reg, qz_reg);
        ha_next       = ggh_pkg::halo_addr(face_hi, qx_reg, qy_reg, qz_reg);
        sel_prev_halo = at_lo && mask_lo;
        sel_next_halo = at_hi && mask_hi;
    end

    // grid store
    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[ggh_pkg::grid_addr(item.pos_x, item.pos_y, item.pos_z)] <= item.sample;
        grid_prev_reg <= grid_mem[ga_prev];
        grid_next_reg <= grid_mem[ga_next];
    end

    // halo store
    always_ff @(posedge clk)
    begin
        if (halo_we)
            halo_mem[ggh_pkg::halo_addr(item.face, item.pos_x, item.pos_y, item.pos_z)]
                <= item.sample;
        halo_prev_reg <= halo_mem[ha_prev];
        halo_next_reg <= halo_mem[ha_next];
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        rd_axis_reg     <= issue_axis_reg;
        rd_sel_prev_reg <= sel_prev_halo;
        rd_sel_next_reg <= sel_next_halo;
    end

    // difference in 33 bits, times the unsigned scale
    assign prev_val = rd_sel_prev_reg ? halo_prev_reg : grid_prev_reg;
    assign next_val = rd_sel_next_reg ? halo_next_reg : grid_next_reg;
    assign diff     = $signed({next_val[ggh_pkg::DATA_W-1], next_val})
                    - $signed({prev_val[ggh_pkg::DATA_W-1], prev_val});
    assign prod     = diff * $signed({1'b0, inv_res_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else
            mul_vld_reg <= rd_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod;
        mul_axis_reg <= rd_axis_reg;
    end

    // arithmetic shift by 16 then saturate: fits when the bits above the kept word agree with its sign bit
    assign top_bits = prod_reg[ggh_pkg::PROD_W-1:ggh_pkg::FRAC_W+ggh_pkg::DATA_W-1];
    assign sat      = !((&top_bits) || !(|top_bits));
    always_comb
    begin
        if (!sat)
            comp = prod_reg[ggh_pkg::FRAC_W+ggh_pkg::DATA_W-1:ggh_pkg::FRAC_W];
        else if (prod_reg[ggh_pkg::PROD_W-1])
            comp = {1'b1, {(ggh_pkg::DATA_W-1){1'b0}}};
        else
            comp = {1'b0, {(ggh_pkg::DATA_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (query_ok)
            clip_reg <= 1'b0;
        else if (mul_vld_reg)
            clip_reg <= clip_reg | sat;
        if (mul_vld_reg)
        begin
            case (mul_axis_reg)
                ggh_pkg::AXIS_X: result_reg.grad_x <= comp;
                ggh_pkg::AXIS_Y: result_reg.grad_y <= comp;
                default:
                begin
                    result_reg.grad_z  <= comp;
                    result_reg.clipped <= clip_reg | sat;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= mul_vld_reg && (mul_axis_reg == ggh_pkg::AXIS_Z);
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_read_feeds_mul: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |=> mul_vld_reg)
        else $error("read stage item lost before multiply");

    a_last_axis_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        mul_vld_reg && (mul_axis_reg == ggh_pkg::AXIS_Z) |=> result_valid)
        else $error("last axis did not produce a result");

    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg) == ggh_pkg::ST_DRAIN) && !busy)
        else $error("result outside the end of a query");

    a_no_store_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg || mul_vld_reg) |-> !(grid_we || halo_we))
        else $error("store written while a query is reading");

    a_issue_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        query_ok |=> issue && (issue_axis_reg == ggh_pkg::AXIS_X))
        else $error("query did not start issuing reads");
`endif

endmodule

`default_nettype wire
